FILE: design/mfcp_pkg.sv
// Shared types for the MSB-first code packer: controller states, commands and status.
package mfcp_pkg;

   // Request kind carried on req_tuser.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Field widths of the stream payloads.
   localparam int CODE_VALUE_W  = 32;
   localparam int CODE_LENGTH_W = 6;
   localparam int REQ_TDATA_W   = 40;
   localparam int BYTE_W        = 8;

   // Controller states.
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture a request item into the bit accumulator
      logic emit;    // move the top byte of the accumulator to the output register
      logic finish;  // store the leftover bits back as the partial byte
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_byte;  // at least eight bits wait in the accumulator
      logic out_free;  // the output register can take a byte this cycle
   } status_type;

endpackage

FILE: design/msb_first_code_packer.sv
// Top level of the MSB-first code packer: stream ports, controller and datapath.
// The first byte of an item passes through the accumulator and then the output register.
// An item completes 0 to 4 bytes for 32-bit codes; the controller drains the accumulator one byte
// per cycle while the output register is free, then stores the remainder before taking the next item.
// Reset (synchronous, active high) empties the partial byte and the output register.
module msb_first_code_packer
   import mfcp_pkg::*;
#(
   parameter int MAX_CODE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] code_value, [37:32] code_length, [39:38] zero
   input  logic                   req_tuser,   // [0] op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                   rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of load, drain and store.
   mfcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Bit packing and output register.
   mfcp_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_tuser),
      .req_code_value  (req_tdata[CODE_VALUE_W-1:0]),
      .req_code_length (req_tdata[CODE_VALUE_W +: CODE_LENGTH_W]),
      .cmd             (cmd),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_byte        (rsp_tdata),
      .rsp_last        (rsp_tlast)
   );

endmodule

FILE: design/mfcp_ctrl.sv
// Controller state machine of the MSB-first code packer.
module mfcp_ctrl
   import mfcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // Take one item and load it into the accumulator.
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Drain whole bytes one per cycle while the output register is free, then keep the remainder.
            if (status.has_byte) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/mfcp_datapath.sv
// Datapath of the MSB-first code packer: bit accumulator, partial byte and output register.
module mfcp_datapath
   import mfcp_pkg::*;
#(
   parameter int MAX_CODE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_op,
   input  logic [CODE_VALUE_W-1:0]  req_code_value,
   input  logic [CODE_LENGTH_W-1:0] req_code_length,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [BYTE_W-1:0]        rsp_byte,
   output logic                     rsp_last
);

   // Accumulator holds up to seven pending bits followed by one whole code.
   localparam int AccW   = MAX_CODE_BITS + 7;
   localparam int CountW = $clog2(MAX_CODE_BITS + 8);
   localparam int ExtW   = 64;
   localparam logic [CODE_LENGTH_W-1:0] MaxLen = CODE_LENGTH_W'(MAX_CODE_BITS);

   logic [BYTE_W-1:0]        partial_ff;
   logic [2:0]               filled_ff;
   logic [AccW-1:0]          acc_ff;
   logic [CountW-1:0]        count_ff;
   logic                     rsp_valid_ff;
   logic [BYTE_W-1:0]        rsp_byte_ff;
   logic                     rsp_last_ff;

   logic [CODE_LENGTH_W-1:0] len_sat;
   logic [ExtW-1:0]          value_ext;
   logic [MAX_CODE_BITS-1:0] code_ext;
   logic [MAX_CODE_BITS-1:0] code_aligned;
   logic [AccW-1:0]          code_placed;
   logic [AccW-1:0]          partial_placed;

   // Saturate the length and left-align the code bits below the pending bits.
   always_comb begin
      len_sat        = (req_code_length > MaxLen) ? MaxLen : req_code_length;
      value_ext      = {{(ExtW - CODE_VALUE_W){1'b0}}, req_code_value};
      code_ext       = value_ext[MAX_CODE_BITS-1:0];
      code_aligned   = code_ext << (MaxLen - len_sat);
      code_placed    = {code_aligned, 7'b0} >> filled_ff;
      partial_placed = {partial_ff[7:1], {MAX_CODE_BITS{1'b0}}};
   end

   // Partial byte state.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         filled_ff  <= '0;
      end else if (cmd.finish) begin
         partial_ff <= acc_ff[AccW-1 -: BYTE_W];
         filled_ff  <= count_ff[2:0];
      end
   end

   // Accumulator and bit count: load an item, or drop one emitted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         if (req_op == OP_FLUSH) begin
            acc_ff   <= partial_placed;
            count_ff <= (filled_ff != 3'd0) ? CountW'(8) : '0;
         end else begin
            acc_ff   <= partial_placed | code_placed;
            count_ff <= CountW'(filled_ff) + CountW'(len_sat);
         end
      end else if (cmd.emit) begin
         acc_ff   <= acc_ff << BYTE_W;
         count_ff <= count_ff - CountW'(8);
      end
   end

   // Output register parts the accumulator from the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= acc_ff[AccW-1 -: BYTE_W];
         rsp_last_ff <= (count_ff >> 3) < CountW'(2);
      end
   end

   // Status and outputs.
   assign status.has_byte = count_ff >= CountW'(8);
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_byte        = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the MSB-first code packer: directed and random codes, flushes.
`timescale 1ns / 100ps

module testbench
   import mfcp_pkg::*;
();

   localparam int MAX_CODE_BITS  = 32;
   localparam int RANDOM_ITEMS   = 197;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 1500;
   localparam int HOLD_CYCLES    = 200;

   // One request item and one expected output byte.
   typedef struct packed {
      logic                     op;
      logic [CODE_VALUE_W-1:0]  value;
      logic [CODE_LENGTH_W-1:0] length;
   } code_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } packed_byte_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] code_value, [37:32] code_length, [39:38] zero
   logic                   req_tuser  = 1'b0; // [0] op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [BYTE_W-1:0]      rsp_tdata;         // [7:0] out_byte
   logic                   rsp_tlast;

   code_item_type   pending_items[$];
   packed_byte_type expected_bytes[$];
   code_item_type   offered_item;

   // Predicted state of the partial byte.
   logic [7:0] partial_byte = '0;
   int         fill_count   = 0;

   int items_accepted = 0;
   int bytes_checked  = 0;
   int flush_count    = 0;
   int long_count     = 0;
   int error_count    = 0;
   int hold_left      = 0;
   logic hold_done    = 1'b0;
   int idle_cycles    = 0;
   logic calm;

   msb_first_code_packer #(.MAX_CODE_BITS(MAX_CODE_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A window of items during which neither side idles.
   assign calm = (items_accepted >= 120) && (items_accepted < 170);

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Updates the partial byte with one accepted item and queues the bytes it completes.
   task automatic pack_code_item(input code_item_type it);
      logic [7:0] done_bytes[4];
      int done_n;
      int nbits;
      int pos;
      done_n = 0;
      if (it.op == OP_FLUSH) begin
         if (fill_count != 0) expected_bytes.push_back('{partial_byte, 1'b1});
         partial_byte = '0;
         fill_count   = 0;
      end else begin
         nbits = (it.length > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(it.length);
         for (pos = nbits - 1; pos >= 0; pos--) begin
            partial_byte[7 - fill_count] = (pos < CODE_VALUE_W) ? it.value[pos] : 1'b0;
            if (fill_count == 7) begin
               done_bytes[done_n] = partial_byte;
               done_n++;
               partial_byte = '0;
               fill_count   = 0;
            end else begin
               fill_count++;
            end
         end
         for (pos = 0; pos < done_n; pos++)
            expected_bytes.push_back('{done_bytes[pos], pos == done_n - 1});
      end
   endtask

   task automatic queue_item(input logic op, input logic [31:0] value, input logic [5:0] length);
      pending_items.push_back('{op, value, length});
      if (op == OP_FLUSH) flush_count++;
      else if (length > MAX_CODE_BITS) long_count++;
   endtask

   // Stimulus and end of run.
   initial begin
      int i;
      int sel;
      logic op;
      logic [31:0] value;
      logic [5:0] length;

      // Directed part: empty flush, zero length, full-width codes, saturation,
      // partial bytes that do or do not complete, ignored flush fields.
      queue_item(OP_FLUSH,  32'hFFFF_FFFF, 6'd63);
      queue_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
      queue_item(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
      queue_item(OP_APPEND, 32'h0000_0000, 6'd32);
      queue_item(OP_APPEND, 32'h8000_0001, 6'd32);
      queue_item(OP_APPEND, 32'h0000_0001, 6'd1);
      queue_item(OP_APPEND, 32'h0000_007F, 6'd7);
      queue_item(OP_APPEND, 32'h0000_0055, 6'd7);
      queue_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
      queue_item(OP_APPEND, 32'h0000_0001, 6'd1);
      queue_item(OP_APPEND, 32'h0000_0005, 6'd3);
      queue_item(OP_APPEND, 32'hA5A5_A5A5, 6'd32);
      queue_item(OP_FLUSH,  32'h0000_0000, 6'd0);
      queue_item(OP_FLUSH,  32'h1234_5678, 6'd17);
      queue_item(OP_APPEND, 32'hA5A5_A5A5, 6'd63);
      queue_item(OP_APPEND, 32'h5A5A_5A5A, 6'd33);
      queue_item(OP_APPEND, 32'h0000_0003, 6'd2);
      queue_item(OP_APPEND, 32'hC3C3_C3C3, 6'd40);
      queue_item(OP_APPEND, 32'h0000_00E1, 6'd8);
      queue_item(OP_FLUSH,  32'hFFFF_FFFF, 6'd32);
      queue_item(OP_APPEND, 32'h0000_0001, 6'd5);
      queue_item(OP_FLUSH,  32'hDEAD_BEEF, 6'd63);

      // Random part: mostly ordinary lengths, some full, zero and oversized ones.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         op    = ($urandom_range(0, 99) < 15) ? OP_FLUSH : OP_APPEND;
         value = $urandom();
         sel   = $urandom_range(0, 9);
         if (sel == 0) value = '0;
         else if (sel == 1) value = '1;
         sel = $urandom_range(0, 99);
         if (sel < 10) length = 6'($urandom_range(33, 63));
         else if (sel < 22) length = 6'd32;
         else if (sel < 27) length = 6'd0;
         else length = 6'($urandom_range(1, 31));
         queue_item(op, value, length);
      end
      queue_item(OP_FLUSH, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      $display("Run covered %0d items, %0d of them flushes and %0d with oversized lengths.",
               items_accepted, flush_count, long_count);
      $display("%0d output bytes were checked, including a long receiver stall.", bytes_checked);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Request driver: offers queued items, predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pack_code_item(offered_item);
            items_accepted <= items_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
               offered_item = pending_items.pop_front();
               req_tdata  <= {2'b00, offered_item.length, offered_item.value};
               req_tuser  <= offered_item.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off once the run is under way.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= 60) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Result monitor: checks each accepted byte against the oldest prediction.
   always @(posedge clock) begin
      packed_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_tdata, want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last_of_item %b, expected %b on byte %02h",
                                            rsp_tlast, want.last, want.data));
            end
            bytes_checked++;
         end
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 20);
      end
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles with no item moving.", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
